// ===== hdl/image_convolution_2d_valid_assert.svh =====
// Assertion macros shared by the convolution block.
`ifndef IMAGE_CONVOLUTION_2D_VALID_ASSERT_SVH
`define IMAGE_CONVOLUTION_2D_VALID_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define ICV_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define ICV_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);
`else
`define ICV_ASSERT_IMP(lbl, ck, rs, ante, cons, msg)
`define ICV_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg)
`endif
`endif

// ===== hdl/icv_pkg.sv =====
// Shared constants, types and helpers of the 2D convolution block.
package icv_pkg;

  localparam int MAX_KERNEL_DEF = 5;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int KCOLS          = 5;
  localparam int PIX_W          = 8;
  localparam int COEF_W         = 12;
  localparam int KROW_W         = 60;
  localparam int PROD_W         = 20;
  localparam int RSUM_W         = 23;
  localparam int SUM_W          = 25;
  localparam int KSIZE_W        = 3;
  localparam int IMW_W          = 11;
  localparam int IMH_W          = 12;
  localparam int ROW_W          = 12;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 60;
  localparam int FIFO_DEPTH     = 8;
  localparam int FIFO_PTR_W     = 3;
  localparam int FIFO_CNT_W     = 4;

  // Register map of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL_SIZE = 3'd0,
    REG_KROW_0      = 3'd1,
    REG_KROW_1      = 3'd2,
    REG_KROW_2      = 3'd3,
    REG_KROW_3      = 3'd4,
    REG_KROW_4      = 3'd5,
    REG_WIDTH       = 3'd6,
    REG_HEIGHT      = 3'd7
  } cfg_reg_t;

  // Per-pixel tag that rides along the pipeline
  typedef struct packed {
    logic produce;
    logic row_end;
    logic frame_end;
  } icv_tag_t;

  // One finished result
  typedef struct packed {
    logic [SUM_W-1:0] value;
    logic             last_row;
    logic             last_frame;
  } icv_result_t;

  // Unsigned pixel times signed coefficient, exact in PROD_W bits
  function automatic logic signed [PROD_W-1:0] mul_px(
    input logic [PIX_W-1:0]         px,
    input logic signed [COEF_W-1:0] c
  );
    logic signed [PROD_W-1:0] pe;
    logic signed [PROD_W-1:0] ce;
    pe = {{(PROD_W-PIX_W){1'b0}}, px};
    ce = {{(PROD_W-COEF_W){c[COEF_W-1]}}, c};
    return pe * ce;
  endfunction

endpackage

// ===== hdl/icv_line_buf.sv =====
// Line store memory with read-modify-write per pixel, forwarding, and the pixel window.
module icv_line_buf #(
  parameter int MAX_KERNEL = icv_pkg::MAX_KERNEL_DEF,
  parameter int MAX_WIDTH  = icv_pkg::MAX_WIDTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    acc,
  input  logic [icv_pkg::PIX_W-1:0]               px,
  input  logic [$clog2(MAX_WIDTH)-1:0]            col,
  input  logic [icv_pkg::ROW_W-1:0]               row,
  input  icv_pkg::icv_tag_t                       tag,
  output logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][icv_pkg::PIX_W-1:0] win,
  output logic                                    win_valid,
  output icv_pkg::icv_tag_t                       win_tag
);

  localparam int LINES = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = LINES * icv_pkg::PIX_W;

  // One word per column: slot 0 is the row just above, slot d-1 is d rows up
  logic [WW-1:0] mem [MAX_WIDTH];
  logic [WW-1:0] rdata;

  logic                        s1_valid;
  logic [icv_pkg::PIX_W-1:0]   s1_px;
  logic [CW-1:0]               s1_col;
  logic [icv_pkg::ROW_W-1:0]   s1_row;
  icv_pkg::icv_tag_t           s1_tag;
  logic                        fwd_hit;
  logic [WW-1:0]               fwd_word;

  logic [WW-1:0]               cur;
  logic [WW-1:0]               new_word;
  logic [MAX_KERNEL-1:0][icv_pkg::PIX_W-1:0] col_v;

  // Memory port: read on accept, write back in the next cycle
  always_ff @(posedge clk) begin
    if (acc) begin
      rdata <= mem[col];
    end
    if (s1_valid) begin
      mem[s1_col] <= new_word;
    end
  end

  // Stage 1 registers; catch a write to the column being read in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= acc;
    end
    if (acc) begin
      fwd_hit  <= s1_valid && (s1_col == col);
      fwd_word <= new_word;
      s1_px    <= px;
      s1_col   <= col;
      s1_row   <= row;
      s1_tag   <= tag;
    end
  end

  // New column: rows above the frame read as zero
  always_comb begin
    cur      = fwd_hit ? fwd_word : rdata;
    new_word = WW'({cur, s1_px});
    col_v    = '0;
    col_v[MAX_KERNEL-1] = s1_px;
    for (int d = 1; d < MAX_KERNEL; d++) begin
      if (d <= int'(s1_row)) begin
        col_v[MAX_KERNEL-1-d] = cur[(d-1)*icv_pkg::PIX_W +: icv_pkg::PIX_W];
      end
    end
  end

  // Window shifts left by one column per pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      win       <= '0;
      win_valid <= 1'b0;
    end else begin
      win_valid <= s1_valid && s1_tag.produce;
      if (s1_valid) begin
        for (int y = 0; y < MAX_KERNEL; y++) begin
          for (int x = 0; x < MAX_KERNEL - 1; x++) begin
            win[y][x] <= win[y][x+1];
          end
          win[y][MAX_KERNEL-1] <= col_v[y];
        end
      end
    end
    if (s1_valid) begin
      win_tag <= s1_tag;
    end
  end

endmodule

// ===== hdl/icv_mac.sv =====
// Multiply-accumulate pipeline: products, row sums, final sum.
module icv_mac #(
  parameter int MAX_KERNEL = icv_pkg::MAX_KERNEL_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][icv_pkg::PIX_W-1:0] win,
  input  logic                                    win_valid,
  input  icv_pkg::icv_tag_t                       win_tag,
  input  logic [icv_pkg::KCOLS-1:0][icv_pkg::KROW_W-1:0] krows,
  input  logic [icv_pkg::KSIZE_W-1:0]             k,
  output logic                                    res_valid,
  output icv_pkg::icv_result_t                    res
);

  localparam int KU = (MAX_KERNEL < icv_pkg::KCOLS) ? MAX_KERNEL : icv_pkg::KCOLS;

  logic signed [icv_pkg::PROD_W-1:0] prod [KU][KU];
  logic signed [icv_pkg::RSUM_W-1:0] rsum [KU];
  logic signed [icv_pkg::RSUM_W-1:0] rsum_d [KU];
  logic signed [icv_pkg::SUM_W-1:0]  total_d;
  logic                              v2, v3;
  icv_pkg::icv_tag_t                 t2, t3;

  // Products, kernel flipped against the window, outside k masked off
  always_ff @(posedge clk) begin
    for (int a = 0; a < KU; a++) begin
      for (int b = 0; b < KU; b++) begin
        if (a < int'(k) && b < int'(k)) begin
          prod[a][b] <= icv_pkg::mul_px(win[MAX_KERNEL-1-a][MAX_KERNEL-1-b],
            $signed(krows[a][b*icv_pkg::COEF_W +: icv_pkg::COEF_W]));
        end else begin
          prod[a][b] <= '0;
        end
      end
    end
  end

  // Row sums
  always_comb begin
    for (int a = 0; a < KU; a++) begin
      rsum_d[a] = '0;
      for (int b = 0; b < KU; b++) begin
        rsum_d[a] = rsum_d[a] + icv_pkg::RSUM_W'(prod[a][b]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < KU; a++) begin
      rsum[a] <= rsum_d[a];
    end
  end

  // Final sum
  always_comb begin
    total_d = '0;
    for (int a = 0; a < KU; a++) begin
      total_d = total_d + icv_pkg::SUM_W'(rsum[a]);
    end
  end

  // Valid and tag follow the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      v2        <= win_valid;
      v3        <= v2;
      res_valid <= v3;
    end
    t2             <= win_tag;
    t3             <= t2;
    res.value      <= total_d;
    res.last_row   <= t3.row_end;
    res.last_frame <= t3.frame_end;
  end

endmodule

// ===== hdl/image_convolution_2d_valid.sv =====
// Top level of the 2D valid-region convolution block.
// Takes one 8-bit pixel per clock in raster order and returns, for every pixel that
// completes a k x k neighbourhood, the exact signed sum of pixel times Q4.8 coefficient
// (kernel rotated 180 degrees), with row-end and frame-end flags. Sustained rate is one
// pixel per cycle: the line store is one memory word per column holding the rows above,
// read and written back once per pixel, with a forwarding path for one-pixel-wide images.
// A result passes the stage-1, window, product, row-sum and final-sum registers and waits
// in an eight-entry result queue; pixel_stall rises only once eight results are pending
// in the pipeline and queue. The line store needs no clearing after reset: entries are read
// only after they are written in the current frame. Configuration must be written only
// while the block is idle; the block does not enforce this. cfg_ready is always high.
`include "image_convolution_2d_valid_assert.svh"
module image_convolution_2d_valid #(
  parameter int MAX_KERNEL = icv_pkg::MAX_KERNEL_DEF,
  parameter int MAX_WIDTH  = icv_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pixel_valid,
  output logic                              pixel_stall,
  input  logic [icv_pkg::PIX_W-1:0]         pixel,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic signed [icv_pkg::SUM_W-1:0]  filtered_value,
  output logic                              last_in_row,
  output logic                              last_in_frame,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [icv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [icv_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int KU    = (MAX_KERNEL < icv_pkg::KCOLS) ? MAX_KERNEL : icv_pkg::KCOLS;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int CW1   = CW + 1;
  localparam int RW1   = icv_pkg::ROW_W + 1;
  localparam int KBITS = icv_pkg::KCOLS * icv_pkg::KROW_W;

  // Configuration registers
  logic [icv_pkg::KSIZE_W-1:0]                      ksize;
  logic [icv_pkg::KCOLS-1:0][icv_pkg::KROW_W-1:0]   krows;
  logic [icv_pkg::IMW_W-1:0]                        img_w;
  logic [icv_pkg::IMH_W-1:0]                        img_h;

  // Raster position of the next pixel
  logic [CW-1:0]               col_pos;
  logic [icv_pkg::ROW_W-1:0]   row_pos;

  logic [icv_pkg::KSIZE_W-1:0] k_eff;
  logic [CW1-1:0]              w_eff;
  logic [icv_pkg::IMH_W-1:0]   h_eff;
  logic                        acc;
  logic                        row_end;
  logic                        frame_end;
  logic                        produce;
  icv_pkg::icv_tag_t           tag;

  logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][icv_pkg::PIX_W-1:0] win;
  logic                        win_valid;
  icv_pkg::icv_tag_t           win_tag;
  logic                        res_valid;
  icv_pkg::icv_result_t        res;

  // Result queue and credit count
  icv_pkg::icv_result_t            fifo [icv_pkg::FIFO_DEPTH];
  logic [icv_pkg::FIFO_PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [icv_pkg::FIFO_CNT_W-1:0]  fifo_cnt, fifo_cnt_next;
  logic [icv_pkg::FIFO_CNT_W-1:0]  pending, pending_next;
  logic                            pop;

  assign cfg_ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ksize <= icv_pkg::KSIZE_W'(1);
      // row 0 holds 1.0 at column 0, all other coefficients zero
      krows <= KBITS'(256);
      img_w <= icv_pkg::IMW_W'(1024);
      img_h <= icv_pkg::IMH_W'(1024);
    end else if (cfg_valid) begin
      case (icv_pkg::cfg_reg_t'(cfg_index))
        icv_pkg::REG_KERNEL_SIZE: ksize    <= cfg_data[icv_pkg::KSIZE_W-1:0];
        icv_pkg::REG_KROW_0:      krows[0] <= cfg_data;
        icv_pkg::REG_KROW_1:      krows[1] <= cfg_data;
        icv_pkg::REG_KROW_2:      krows[2] <= cfg_data;
        icv_pkg::REG_KROW_3:      krows[3] <= cfg_data;
        icv_pkg::REG_KROW_4:      krows[4] <= cfg_data;
        icv_pkg::REG_WIDTH:       img_w    <= cfg_data[icv_pkg::IMW_W-1:0];
        icv_pkg::REG_HEIGHT:      img_h    <= cfg_data[icv_pkg::IMH_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped settings and per-pixel flags
  always_comb begin
    if (ksize == '0) begin
      k_eff = icv_pkg::KSIZE_W'(1);
    end else if (int'(ksize) > KU) begin
      k_eff = icv_pkg::KSIZE_W'(KU);
    end else begin
      k_eff = ksize;
    end
    if (img_w == '0) begin
      w_eff = CW1'(1);
    end else if (int'(img_w) > MAX_WIDTH) begin
      w_eff = CW1'(MAX_WIDTH);
    end else begin
      w_eff = CW1'(img_w);
    end
    h_eff     = (img_h == '0) ? icv_pkg::IMH_W'(1) : img_h;
    acc       = pixel_valid && !pixel_stall;
    row_end   = (CW1'(col_pos) + CW1'(1)) >= w_eff;
    frame_end = row_end && ((RW1'(row_pos) + RW1'(1)) >= RW1'(h_eff));
    produce   = ((RW1'(row_pos) + RW1'(1)) >= RW1'(k_eff)) &&
                ((CW1'(col_pos) + CW1'(1)) >= CW1'(k_eff));
    tag.produce   = produce;
    tag.row_end   = row_end;
    tag.frame_end = frame_end;
  end

  // Position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (acc) begin
      if (row_end) begin
        col_pos <= '0;
        row_pos <= frame_end ? '0 : row_pos + icv_pkg::ROW_W'(1);
      end else begin
        col_pos <= col_pos + CW'(1);
      end
    end
  end

  icv_line_buf #(
    .MAX_KERNEL (MAX_KERNEL),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_line_buf (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .px        (pixel),
    .col       (col_pos),
    .row       (row_pos),
    .tag       (tag),
    .win       (win),
    .win_valid (win_valid),
    .win_tag   (win_tag)
  );

  icv_mac #(
    .MAX_KERNEL (MAX_KERNEL)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .win       (win),
    .win_valid (win_valid),
    .win_tag   (win_tag),
    .krows     (krows),
    .k         (k_eff),
    .res_valid (res_valid),
    .res       (res)
  );

  // Queue bookkeeping: pending counts results owed from accepted pixels
  assign pop          = result_valid && !result_stall;
  assign pixel_stall  = pending >= icv_pkg::FIFO_CNT_W'(icv_pkg::FIFO_DEPTH);
  assign result_valid = fifo_cnt != '0;

  always_comb begin
    pending_next  = pending + icv_pkg::FIFO_CNT_W'(acc && produce)
                  - icv_pkg::FIFO_CNT_W'(pop);
    fifo_cnt_next = fifo_cnt + icv_pkg::FIFO_CNT_W'(res_valid)
                  - icv_pkg::FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
      pending  <= '0;
    end else begin
      fifo_cnt <= fifo_cnt_next;
      pending  <= pending_next;
      if (res_valid) begin
        wr_ptr <= wr_ptr + icv_pkg::FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + icv_pkg::FIFO_PTR_W'(1);
      end
    end
    if (res_valid) begin
      fifo[wr_ptr] <= res;
    end
  end

  assign filtered_value = $signed(fifo[rd_ptr].value);
  assign last_in_row    = fifo[rd_ptr].last_row;
  assign last_in_frame  = fifo[rd_ptr].last_frame;

  // Checks
  `ICV_ASSERT_IMP(a_push_room, clk, rst, res_valid,
    fifo_cnt < icv_pkg::FIFO_CNT_W'(icv_pkg::FIFO_DEPTH), "result queue overflow")
  `ICV_ASSERT_IMP(a_credit_covers, clk, rst, 1'b1, fifo_cnt <= pending,
    "queued results exceed pending count")
  `ICV_ASSERT_IMP(a_credit_bound, clk, rst, 1'b1,
    pending <= icv_pkg::FIFO_CNT_W'(icv_pkg::FIFO_DEPTH), "pending count beyond queue depth")
  `ICV_ASSERT_NEXT(a_frame_wrap, clk, rst, acc && frame_end,
    (col_pos == '0) && (row_pos == '0), "position did not wrap at frame end")

endmodule

// ===== tb/tb_image_convolution_2d_valid.sv =====
// Self-checking testbench for the 2D valid-region convolution block.
module tb_image_convolution_2d_valid;

  localparam int MAXK  = icv_pkg::MAX_KERNEL_DEF;
  localparam int MAXW  = icv_pkg::MAX_WIDTH_DEF;
  localparam int LINES = (MAXK > 1) ? MAXK - 1 : 1;

  // DUT inputs, known from time zero
  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           pixel_valid = 1'b0;
  logic [icv_pkg::PIX_W-1:0]      pixel = '0;
  logic                           result_stall = 1'b0;
  logic                           cfg_valid = 1'b0;
  icv_pkg::cfg_reg_t              cfg_index = icv_pkg::REG_KERNEL_SIZE;
  logic [icv_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // DUT outputs
  logic                             pixel_stall;
  logic                             result_valid;
  logic signed [icv_pkg::SUM_W-1:0] filtered_value;
  logic                             last_in_row;
  logic                             last_in_frame;
  logic                             cfg_ready;

  // Stimulus and scoreboard
  logic [icv_pkg::PIX_W-1:0] pending_pixels [$];
  icv_pkg::icv_result_t      expected_sums [$];
  int unsigned               items_sent = 0;
  int                        errors = 0;
  bit                        pix_took = 1'b0;
  int unsigned               gap_pct = 15;
  int unsigned               stall_pct = 15;
  bit                        hold_arm = 1'b0;
  int unsigned               hold_cnt = 0;

  // Predictor copy of registers and state
  logic [icv_pkg::KSIZE_W-1:0] k_reg = 3'd1;
  logic [icv_pkg::KROW_W-1:0]  krow [0:4];
  logic [icv_pkg::IMW_W-1:0]   w_reg = 11'd1024;
  logic [icv_pkg::IMH_W-1:0]   h_reg = 12'd1024;
  logic [icv_pkg::PIX_W-1:0]   line_mem [0:LINES*MAXW-1];
  logic [icv_pkg::PIX_W-1:0]   win [0:MAXK-1][0:MAXK-1];
  int unsigned                 col_pos = 0;
  int unsigned                 row_pos = 0;

  image_convolution_2d_valid uut (
    .clk            (clk),
    .rst            (rst),
    .pixel_valid    (pixel_valid),
    .pixel_stall    (pixel_stall),
    .pixel          (pixel),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .filtered_value (filtered_value),
    .last_in_row    (last_in_row),
    .last_in_frame  (last_in_frame),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Effective settings after the block's clamping
  function automatic int unsigned eff_k();
    int unsigned v;
    v = (k_reg == 0) ? 1 : k_reg;
    if (v > MAXK) v = MAXK;
    if (v > icv_pkg::KCOLS) v = icv_pkg::KCOLS;
    return v;
  endfunction

  function automatic int unsigned eff_w();
    if (w_reg == 0) return 1;
    if (w_reg > MAXW) return MAXW;
    return w_reg;
  endfunction

  function automatic int unsigned eff_h();
    return (h_reg == 0) ? 1 : h_reg;
  endfunction

  // Pixels still needed to close the current frame (only valid while idle)
  function automatic int unsigned pixels_left();
    int unsigned w, h, c, r, row_rest;
    w = eff_w();
    h = eff_h();
    c = col_pos % MAXW;
    r = row_pos;
    row_rest = (c + 1 >= w) ? 1 : w - c;
    return row_rest + ((r + 1 >= h) ? 0 : (h - 1 - r) * w);
  endfunction

  // Append one pixel to the driver's queue
  function automatic void queue_pixel(input logic [icv_pkg::PIX_W-1:0] px);
    pending_pixels.insert(pending_pixels.size(), px);
  endfunction

  // Advance the predictor by one pixel and queue the sum it completes, if any
  function automatic void convolve_pixel(input logic [icv_pkg::PIX_W-1:0] px);
    int unsigned                       k, w, h, c, r, slot;
    logic [icv_pkg::PIX_W-1:0]         column [0:MAXK-1];
    logic signed [31:0]                acc;
    logic signed [icv_pkg::COEF_W-1:0] coef;
    icv_pkg::icv_result_t              res;
    bit                                row_end, frame_end;
    k = eff_k();
    w = eff_w();
    h = eff_h();
    c = col_pos % MAXW;
    r = row_pos & 12'hFFF;
    // new window column: current pixel at the bottom, rows above from the line store
    column[MAXK-1] = px;
    for (int d = 1; d < MAXK; d++) begin
      column[MAXK-1-d] = '0;
      if (d <= r) begin
        slot = (r % LINES + LINES - d % LINES) % LINES;
        column[MAXK-1-d] = line_mem[slot*MAXW + c];
      end
    end
    line_mem[(r % LINES)*MAXW + c] = px;
    for (int y = 0; y < MAXK; y++) begin
      for (int x = 0; x + 1 < MAXK; x++) win[y][x] = win[y][x+1];
      win[y][MAXK-1] = column[y];
    end
    row_end = (c + 1 >= w);
    frame_end = row_end && (r + 1 >= h);
    // full neighbourhood seen: kernel applied rotated by 180 degrees
    if (r + 1 >= k && c + 1 >= k) begin
      acc = 0;
      for (int a = 0; a < k; a++)
        for (int b = 0; b < k; b++) begin
          coef = krow[a][12*b +: 12];
          acc = acc + $signed({1'b0, win[MAXK-1-a][MAXK-1-b]}) * coef;
        end
      res.value = acc[icv_pkg::SUM_W-1:0];
      res.last_row = row_end;
      res.last_frame = frame_end;
      expected_sums.insert(expected_sums.size(), res);
    end
    if (row_end) begin
      col_pos = 0;
      row_pos = frame_end ? 0 : (r + 1) & 12'hFFF;
    end else begin
      col_pos = (c + 1) % MAXW;
      row_pos = r;
    end
  endfunction

  // Random Q4.8 kernel row, biased toward the extremes
  function automatic logic [icv_pkg::KROW_W-1:0] random_row();
    logic [icv_pkg::KROW_W-1:0] row;
    for (int i = 0; i < 5; i++)
      case ($urandom_range(7))
        0: row[12*i +: 12] = 12'h800;
        1: row[12*i +: 12] = 12'h7FF;
        2: row[12*i +: 12] = 12'h000;
        default: row[12*i +: 12] = 12'($urandom_range(4095));
      endcase
    return row;
  endfunction

  // Register value with random junk above the used bits now and then
  function automatic logic [icv_pkg::CFG_DATA_W-1:0] noisy(input int unsigned v,
                                                           input int unsigned bits);
    logic [63:0] junk;
    junk = {$urandom, $urandom} << bits;
    return ($urandom_range(3) == 0) ? (junk[59:0] | 60'(v)) : 60'(v);
  endfunction

  function automatic void push_pixels(input int unsigned n);
    logic [icv_pkg::PIX_W-1:0] px;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: px = 8'd0;
        1: px = 8'd255;
        default: px = 8'($urandom_range(255));
      endcase
      queue_pixel(px);
    end
    items_sent += n;
  endfunction

  // One config transaction; the predictor follows at the handshake
  task automatic write_reg(input icv_pkg::cfg_reg_t idx,
                           input logic [icv_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      icv_pkg::REG_KERNEL_SIZE: k_reg = val[icv_pkg::KSIZE_W-1:0];
      icv_pkg::REG_WIDTH:       w_reg = val[icv_pkg::IMW_W-1:0];
      icv_pkg::REG_HEIGHT:      h_reg = val[icv_pkg::IMH_W-1:0];
      default:                  krow[idx - icv_pkg::REG_KROW_0] = val;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every pixel is in and every sum is out, then let the pipeline empty
  task automatic settle();
    @(posedge clk);
    while (pending_pixels.size() != 0 || pixel_valid || expected_sums.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Configure, then stream one whole frame, optionally changing a register partway
  task automatic run_frame(input logic [icv_pkg::CFG_DATA_W-1:0] k_val, w_val, h_val,
                           input bit mid_change);
    int unsigned n;
    int unsigned first;
    write_reg(icv_pkg::REG_KERNEL_SIZE, k_val);
    for (int i = 0; i < 5; i++)
      if ($urandom_range(1))
        write_reg(icv_pkg::cfg_reg_t'(icv_pkg::REG_KROW_0 + i), random_row());
    write_reg(icv_pkg::REG_WIDTH, w_val);
    write_reg(icv_pkg::REG_HEIGHT, h_val);
    n = pixels_left();
    if (mid_change && n > 2) begin
      first = $urandom_range(n - 1, 1);
      push_pixels(first);
      settle();
      // width may only shrink mid-frame, so no unwritten line store entry is read
      case ($urandom_range(3))
        0: write_reg(icv_pkg::REG_KERNEL_SIZE, 60'($urandom_range(7)));
        1: write_reg(icv_pkg::REG_WIDTH, 60'($urandom_range(eff_w(), 1)));
        2: write_reg(icv_pkg::REG_HEIGHT, 60'($urandom_range(15)));
        default: write_reg(icv_pkg::cfg_reg_t'(icv_pkg::REG_KROW_0 + $urandom_range(4)),
                           random_row());
      endcase
      n = pixels_left();
    end
    push_pixels(n);
    settle();
  endtask

  // Pixel driver
  always @(negedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (!pixel_valid || pix_took) begin
      if (pending_pixels.size() > 0 && $urandom_range(99) >= gap_pct) begin
        pixel <= pending_pixels.pop_front();
        pixel_valid <= 1'b1;
      end else begin
        pixel_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus one long hold-off when armed
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_cnt > 0) begin
      result_stall <= 1'b1;
      hold_cnt--;
    end else if (hold_arm) begin
      hold_arm = 1'b0;
      hold_cnt = 120;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: predict on each accepted pixel, check each accepted result
  always @(posedge clk) begin
    icv_pkg::icv_result_t want;
    if (rst) begin
      pix_took = 1'b0;
    end else begin
      pix_took = pixel_valid && !pixel_stall;
      if (pix_took) convolve_pixel(pixel);
      if (result_valid && !result_stall) begin
        if (expected_sums.size() == 0) begin
          $error("unexpected result transaction, filtered_value %0d", filtered_value);
          errors++;
        end else begin
          want = expected_sums.pop_front();
          if (filtered_value !== want.value) begin
            $error("filtered_value: expected %0d, got %0d", $signed(want.value),
                   filtered_value);
            errors++;
          end
          if (last_in_row !== want.last_row) begin
            $error("last_in_row: expected %0b, got %0b", want.last_row, last_in_row);
            errors++;
          end
          if (last_in_frame !== want.last_frame) begin
            $error("last_in_frame: expected %0b, got %0b", want.last_frame, last_in_frame);
            errors++;
          end
        end
      end
    end
  end

  // Main sequence
  initial begin
    int unsigned kval, wval, hval;
    foreach (krow[i]) krow[i] = '0;
    krow[0] = 60'd256;
    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (win[i, j]) win[i][j] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // reset kernel is a 1x1 identity: each pixel comes back scaled by 256
    queue_pixel(8'd0);
    queue_pixel(8'd255);
    settle();
    // row shrunk below the current column: next pixel closes the row
    write_reg(icv_pkg::REG_WIDTH, 60'd1);
    queue_pixel(8'h5A);
    settle();
    // frame shrunk so the next row end closes it
    write_reg(icv_pkg::REG_HEIGHT, 60'd2);
    push_pixels(pixels_left());
    settle();

    // most negative sum: 5x5 of the minimum coefficient over a saturated frame
    write_reg(icv_pkg::REG_KERNEL_SIZE, 60'd5);
    for (int i = 0; i < 5; i++)
      write_reg(icv_pkg::cfg_reg_t'(icv_pkg::REG_KROW_0 + i), {5{12'h800}});
    write_reg(icv_pkg::REG_WIDTH, 60'd5);
    write_reg(icv_pkg::REG_HEIGHT, 60'd5);
    repeat (25) queue_pixel(8'd255);
    settle();

    // tallest frame, cut short partway down
    write_reg(icv_pkg::REG_KERNEL_SIZE, 60'd2);
    write_reg(icv_pkg::REG_WIDTH, 60'd3);
    write_reg(icv_pkg::REG_HEIGHT, 60'd4095);
    push_pixels(14);
    settle();
    write_reg(icv_pkg::REG_HEIGHT, 60'd2);
    push_pixels(pixels_left());
    settle();

    // clamped and degenerate settings
    run_frame(60'd0, 60'd6, 60'd3, 1'b0);   // kernel size zero acts as 1
    run_frame(60'd7, 60'd9, 60'd7, 1'b0);   // oversize kernel clamps to 5
    run_frame(60'd6, 60'd5, 60'd5, 1'b0);
    run_frame(60'd1, 60'd0, 60'd5, 1'b0);   // width zero acts as 1
    run_frame(60'd1, 60'd7, 60'd0, 1'b0);   // height zero acts as 1
    run_frame(60'd5, 60'd3, 60'd8, 1'b0);   // kernel larger than image: no sums

    // whole frame at full rate on both sides
    gap_pct = 0;
    stall_pct = 0;
    run_frame(60'd3, 60'd24, 60'd5, 1'b0);
    gap_pct = 15;
    stall_pct = 15;

    // receiver holds off while pixels keep coming, so the input backs up
    hold_arm = 1'b1;
    gap_pct = 0;
    run_frame(60'd3, 60'd16, 60'd8, 1'b0);
    gap_pct = 15;

    // random frames
    while (items_sent < 750) begin
      kval = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(5, 1);
      wval = ($urandom_range(5) == 0) ? $urandom_range(40, 1) : $urandom_range(12, 1);
      hval = $urandom_range(10, 1);
      run_frame(noisy(kval, icv_pkg::KSIZE_W), noisy(wval, icv_pkg::IMW_W),
                noisy(hval, icv_pkg::IMH_W), $urandom_range(3) == 0);
    end

    settle();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("[image_convolution_2d_valid] OK");
    else
      $display("[image_convolution_2d_valid] ERROR");
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("[image_convolution_2d_valid] ERROR");
    $finish;
  end

endmodule
